### rtl/core/vbbq_pkg.sv
// Package for the voice band biquad filter.
// Holds the fixed feedback and gain coefficients, the MAC control struct
// and the shared fixed-point constants. No dependencies.
`default_nettype none

package vbbq_pkg;

  localparam int CoefBits = 24;
  localparam int CoefFrac = 22;
  localparam int OutFrac  = 31;
  localparam int LoBits   = 16;
  localparam int InShift  = 9;

  localparam logic [1:0] COEF_A1   = 2'd0;
  localparam logic [1:0] COEF_A2   = 2'd1;
  localparam logic [1:0] COEF_GAIN = 2'd2;

  localparam logic [1:0] PAIR_LAST = 2'd2;

  typedef struct packed {
    logic       en;
    logic       hi;
    logic [1:0] sel;
    logic [1:0] pair;
  } mac_ctrl_t;

  function automatic logic signed [CoefBits-1:0] coef(input logic [1:0] pair,
                                                      input logic [1:0] sel);
    logic signed [CoefBits-1:0] c;
    c = '0;
    if (sel == COEF_GAIN) begin
      c = 24'sd1715432;
    end else if (sel == COEF_A1) begin
      case (pair)
        2'd0:    c = 24'sd6541709;
        2'd1:    c = -24'sd6125218;
        2'd2:    c = 24'sd248217;
        default: c = '0;
      endcase
    end else begin
      case (pair)
        2'd0:    c = -24'sd2910470;
        2'd1:    c = -24'sd2714334;
        2'd2:    c = 24'sd1547360;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/voice_band_biquad_filter.sv
// Top level of the voice band filter: cascaded transposed direct-form-II
// band-pass sections and output gain, sequenced over one shared MAC.
// Depends on vbbq_pkg and vbbq_mac.
//
//   channel   valid        stall        payload
//   input     in_valid_i   in_stall_o   sample_in_i
//   output    out_valid_o  out_stall_i  sample_out_o, clipped_o
//
// Samples are sequenced state by state over the single multiplier,
// which does two partial products per coefficient.
// A new sample is taken while the previous result still waits in the
// output register; the final step holds while that register is stalled.
// Reset clears the section delay state and the sequencer.
`default_nettype none

module voice_band_biquad_filter #(
  parameter int NUM_STAGES = 3,
  parameter int STATE_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [15:0] sample_in_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [15:0] sample_out_o,
  output      logic               clipped_o
);

  localparam int XW    = (STATE_BITS > 25) ? STATE_BITS : 25;
  localparam int SumW  = XW + 3;
  localparam int AccW  = STATE_BITS + 25;
  localparam int RW    = AccW - vbbq_pkg::CoefFrac;
  localparam int OW    = AccW - vbbq_pkg::OutFrac;
  localparam int Depth = 2 * NUM_STAGES;
  localparam int IW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  localparam logic signed [SumW-1:0] ST_MAX = {{(SumW-STATE_BITS+1){1'b0}},
                                               {(STATE_BITS-1){1'b1}}};
  localparam logic signed [SumW-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [OW-1:0]   O_MAX  = OW'(32767);
  localparam logic signed [OW-1:0]   O_MIN  = OW'(-32768);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_Y    = 4'd1;
  localparam logic [3:0] S_M1L  = 4'd2;
  localparam logic [3:0] S_M1H  = 4'd3;
  localparam logic [3:0] S_D1   = 4'd4;
  localparam logic [3:0] S_M2L  = 4'd5;
  localparam logic [3:0] S_M2H  = 4'd6;
  localparam logic [3:0] S_D2   = 4'd7;
  localparam logic [3:0] S_GL   = 4'd8;
  localparam logic [3:0] S_GH   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  function automatic logic signed [STATE_BITS-1:0] sat_st(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] c;
    c = v;
    if (v > ST_MAX) begin
      c = ST_MAX;
    end else if (v < ST_MIN) begin
      c = ST_MIN;
    end
    return STATE_BITS'(c);
  endfunction

  logic [3:0]                    state_d, state_q;
  logic [SW-1:0]                 stage_d, stage_q;
  logic [1:0]                    pair_d, pair_q;
  logic signed [XW-1:0]          x_d, x_q;
  logic signed [STATE_BITS-1:0]  y_d, y_q;
  logic signed [STATE_BITS-1:0]  dly_q [Depth];
  logic [IW-1:0]                 rd_idx;
  logic [IW-1:0]                 wr_idx;
  logic                          dly_we;
  logic signed [STATE_BITS-1:0]  dly_wdata;
  logic signed [STATE_BITS-1:0]  dly_rd;
  logic signed [AccW-1:0]        acc;
  logic signed [RW-1:0]          rnd_val;
  logic signed [OW-1:0]          out_val;
  vbbq_pkg::mac_ctrl_t           mac_ctrl;
  logic                          out_load;
  logic                          out_valid_q;
  logic signed [15:0]            sample_out_d, sample_out_q;
  logic                          clipped_d, clipped_q;
  logic                          last_stage;

  vbbq_mac #(
    .STATE_BITS(STATE_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .oper_i (y_q),
    .acc_o  (acc)
  );

  // d1 is read in S_Y and written in S_D1; d2 is read in S_D1 and written in S_D2
  assign rd_idx     = IW'({stage_q, (state_q == S_D1 || state_q == S_D2)});
  assign wr_idx     = IW'({stage_q, (state_q == S_D2)});
  assign dly_rd     = dly_q[rd_idx];
  assign rnd_val    = acc[AccW-1:vbbq_pkg::CoefFrac];
  assign out_val    = acc[AccW-1:vbbq_pkg::OutFrac];
  assign last_stage = (stage_q == SW'(NUM_STAGES - 1));

  always_comb begin
    mac_ctrl      = '0;
    mac_ctrl.pair = pair_q;
    case (state_q)
      S_M1L, S_M1H: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.hi  = (state_q == S_M1H);
        mac_ctrl.sel = vbbq_pkg::COEF_A1;
      end
      S_M2L, S_M2H: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.hi  = (state_q == S_M2H);
        mac_ctrl.sel = vbbq_pkg::COEF_A2;
      end
      S_GL, S_GH: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.hi  = (state_q == S_GH);
        mac_ctrl.sel = vbbq_pkg::COEF_GAIN;
      end
      default: begin
        mac_ctrl.en  = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    stage_d      = stage_q;
    pair_d       = pair_q;
    x_d          = x_q;
    y_d          = y_q;
    dly_we       = 1'b0;
    dly_wdata    = '0;
    out_load     = 1'b0;
    sample_out_d = sample_out_q;
    clipped_d    = clipped_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d     = XW'(sample_in_i) <<< vbbq_pkg::InShift;
          stage_d = '0;
          pair_d  = '0;
          state_d = S_Y;
        end
      end
      S_Y: begin
        y_d     = sat_st(SumW'(x_q) + SumW'(dly_rd));
        state_d = S_M1L;
      end
      S_M1L:   state_d = S_M1H;
      S_M1H:   state_d = S_D1;
      S_D1: begin
        dly_we    = 1'b1;
        dly_wdata = sat_st(SumW'(rnd_val) + SumW'(dly_rd));
        state_d   = S_M2L;
      end
      S_M2L:   state_d = S_M2H;
      S_M2H:   state_d = S_D2;
      S_D2: begin
        dly_we    = 1'b1;
        dly_wdata = sat_st(SumW'(rnd_val) - SumW'(x_q));
        x_d       = XW'(y_q);
        if (last_stage) begin
          state_d = S_GL;
        end else begin
          stage_d = stage_q + SW'(1);
          pair_d  = (pair_q == vbbq_pkg::PAIR_LAST) ? 2'd0 : pair_q + 2'd1;
          state_d = S_Y;
        end
      end
      S_GL:    state_d = S_GH;
      S_GH:    state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (out_val > O_MAX) begin
            sample_out_d = 16'sd32767;
            clipped_d    = 1'b1;
          end else if (out_val < O_MIN) begin
            sample_out_d = -16'sd32768;
            clipped_d    = 1'b1;
          end else begin
            sample_out_d = 16'(out_val);
            clipped_d    = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stage_q     <= '0;
      pair_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      pair_q      <= pair_d;
      out_valid_q <= out_load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    y_q          <= y_d;
    sample_out_q <= sample_out_d;
    clipped_q    <= clipped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        dly_q[i] <= '0;
      end
    end else if (dly_we) begin
      dly_q[wr_idx] <= dly_wdata;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

endmodule

`default_nettype wire

### rtl/core/vbbq_mac.sv
// Shared multiply-accumulate unit: state word times Q2.22 coefficient,
// done as two partial products, low then high, rounding constant folded in.
// Depends on vbbq_pkg.
`default_nettype none

module vbbq_mac #(
  parameter int STATE_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire vbbq_pkg::mac_ctrl_t             ctrl_i,
  input  wire logic signed [STATE_BITS-1:0]    oper_i,
  output      logic signed [STATE_BITS+24:0]   acc_o
);

  localparam int AccW = STATE_BITS + 25;
  localparam int HiW  = STATE_BITS - vbbq_pkg::LoBits;
  localparam int AW   = (HiW > vbbq_pkg::LoBits + 1) ? HiW : vbbq_pkg::LoBits + 1;

  localparam logic signed [AccW-1:0] RND_SEC = AccW'(64'sd2097152);
  localparam logic signed [AccW-1:0] RND_OUT = AccW'(64'sd2097152 + 64'sd1073741824);

  logic signed [AW-1:0]                     mul_a;
  logic signed [vbbq_pkg::CoefBits-1:0]     mul_b;
  logic signed [AW+vbbq_pkg::CoefBits-1:0]  prod;
  logic signed [AccW-1:0]                   prod_ext;
  logic signed [AccW-1:0]                   acc_d, acc_q;

  always_comb begin
    if (ctrl_i.hi) begin
      mul_a = AW'(signed'(oper_i[STATE_BITS-1:vbbq_pkg::LoBits]));
    end else begin
      mul_a = AW'(signed'({1'b0, oper_i[vbbq_pkg::LoBits-1:0]}));
    end
  end

  assign mul_b    = vbbq_pkg::coef(ctrl_i.pair, ctrl_i.sel);
  assign prod     = mul_a * mul_b;
  assign prod_ext = AccW'(prod);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.en) begin
      if (ctrl_i.hi) begin
        acc_d = acc_q + (prod_ext <<< vbbq_pkg::LoBits);
      end else if (ctrl_i.sel == vbbq_pkg::COEF_GAIN) begin
        acc_d = prod_ext + RND_OUT;
      end else begin
        acc_d = prod_ext + RND_SEC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire
